/* hw/rtl/zlb_pkg.sv */
package zlb_pkg;

  // default field formats
  localparam int unsigned MOMENTUM_WIDTH_DEF = 32;
  localparam int unsigned FRACTION_BITS_DEF  = 17;

  // fixed internal formats
  localparam int unsigned COEF_BITS     = 30;  // gamma and beta*gamma are Q.30
  localparam int unsigned ROOT_BITS     = 32;  // sqrt(x1*x2) in Q.31
  localparam int unsigned RADICAND_BITS = 64;
  localparam int unsigned NUM_BITS      = 63;  // fraction sum scaled to Q.61
  localparam int unsigned DEN_BITS      = ROOT_BITS + 1;
  localparam int unsigned PREM_BITS     = DEN_BITS + 1;

endpackage

/* hw/rtl/z_lorentz_boost.sv */
// throughput: one word per cycle while the output is not stalled; set by a 32-stage
//   square root pipeline and two radix-2 divider pipelines of 32 + FRACTION_BITS
//   stages that also accumulate products
// a stalled result freezes the whole pipeline, no word is lost or repeated
// reset clears all valid bits; data registers are not reset
module z_lorentz_boost #(
  parameter int unsigned MOMENTUM_WIDTH = zlb_pkg::MOMENTUM_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS  = zlb_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic        [FRACTION_BITS:0]    fraction_one_i,
  input  logic        [FRACTION_BITS:0]    fraction_two_i,
  input  logic        [MOMENTUM_WIDTH-2:0] energy_in_i,
  input  logic signed [MOMENTUM_WIDTH-1:0] momentum_z_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [MOMENTUM_WIDTH-1:0] energy_out_o,
  output logic signed [MOMENTUM_WIDTH-1:0] momentum_z_out_o,
  output logic                             saturated_o
);

  localparam int unsigned W    = MOMENTUM_WIDTH;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned XW   = F + 1;
  localparam int unsigned SW   = F + 2;
  localparam int unsigned OW   = W + 1;
  localparam int unsigned QW   = 31 + F;
  localparam int unsigned AW   = W + QW + 2;
  localparam int unsigned CB   = zlb_pkg::COEF_BITS;
  localparam int unsigned RDW  = AW - CB;
  localparam int unsigned RB   = zlb_pkg::ROOT_BITS;
  localparam int unsigned REMW = zlb_pkg::RADICAND_BITS;
  localparam int unsigned NW   = zlb_pkg::NUM_BITS;
  localparam int unsigned DW   = zlb_pkg::DEN_BITS;
  localparam int unsigned RW   = zlb_pkg::PREM_BITS;
  localparam int unsigned PW   = 2 * SW + 4 * OW;
  localparam int unsigned NSH  = 61 - F;
  localparam int unsigned VSH  = 62 - 2 * F;
  localparam int unsigned TW   = REMW + 2;

  // zero is taken as the smallest step, above one as one
  function automatic logic [XW-1:0] clamp_frac(input logic [XW-1:0] raw);
    logic [XW-1:0] one;
    one = XW'(1) << F;
    if (raw == '0) begin
      return XW'(1);
    end else if (raw > one) begin
      return one;
    end
    return raw;
  endfunction

  logic adv;

  // whole pipeline moves unless a finished word is held at the output
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: clamp fractions
  logic          s1_vld_q;
  logic [XW-1:0] s1_x1_q, s1_x2_q;
  logic          s1_act_q;
  logic [W-2:0]  s1_e_q;
  logic [W-1:0]  s1_pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x1_q  <= clamp_frac(fraction_one_i);
      s1_x2_q  <= clamp_frac(fraction_two_i);
      s1_act_q <= action_i;
      s1_e_q   <= energy_in_i;
      s1_pz_q  <= momentum_z_in_i;
    end
  end

  // stage 2: product, sum, difference and signed operands
  logic            s2_vld_q;
  logic [2*XW-1:0] s2_prod_q;
  logic [PW-1:0]   s2_pl_q;
  logic            bg_neg;
  logic [OW-1:0]   ex, pzx, op_a2, op_b2;
  logic [SW-1:0]   sum_d, dif_d;

  always_comb begin
    bg_neg = (s1_x1_q < s1_x2_q) ^ s1_act_q;
    ex     = {2'b00, s1_e_q};
    pzx    = {s1_pz_q[W-1], s1_pz_q};
    op_a2  = bg_neg ? pzx : -pzx;
    op_b2  = bg_neg ? ex : -ex;
    sum_d  = SW'(s1_x1_q) + SW'(s1_x2_q);
    dif_d  = (s1_x1_q >= s1_x2_q) ? SW'(s1_x1_q - s1_x2_q) : SW'(s1_x2_q - s1_x1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_prod_q <= s1_x1_q * s1_x2_q;
      s2_pl_q   <= {sum_d, dif_d, ex, op_a2, pzx, op_b2};
    end
  end

  // square root pipeline, one root bit per stage
  logic            sq_vld_q  [RB];
  logic [REMW-1:0] sq_rem_q  [RB];
  logic [RB-1:0]   sq_root_q [RB];
  logic [PW-1:0]   sq_pl_q   [RB];

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int unsigned B = RB - 1 - k;
    logic            vld_s;
    logic [REMW-1:0] rem_s, rem_n;
    logic [RB-1:0]   root_s, root_n;
    logic [PW-1:0]   pl_s;
    logic [TW-1:0]   trial;

    if (k == 0) begin : g_src0
      assign vld_s  = s2_vld_q;
      assign rem_s  = REMW'(s2_prod_q) << VSH;
      assign root_s = '0;
      assign pl_s   = s2_pl_q;
    end else begin : g_srck
      assign vld_s  = sq_vld_q[k-1];
      assign rem_s  = sq_rem_q[k-1];
      assign root_s = sq_root_q[k-1];
      assign pl_s   = sq_pl_q[k-1];
    end

    // try setting this root bit
    always_comb begin
      trial = (TW'(root_s) << (B + 1)) + (TW'(1) << (2 * B));
      if (TW'(rem_s) >= trial) begin
        rem_n  = rem_s - trial[REMW-1:0];
        root_n = root_s | (RB'(1) << B);
      end else begin
        rem_n  = rem_s;
        root_n = root_s;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k]  <= rem_n;
        sq_root_q[k] <= root_n;
        sq_pl_q[k]   <= pl_s;
      end
    end
  end

  // divider pipelines for gamma and beta*gamma, with msb-first product accumulation
  logic          dv_vld_q [QW+1];
  logic [PW-1:0] dv_pl_q  [QW+1];
  logic [DW-1:0] dv_den_q [QW+1];
  logic [RW-1:0] dv_rg_q  [QW+1];
  logic [RW-1:0] dv_rb_q  [QW+1];
  logic          dv_qg_q  [QW+1];
  logic          dv_qb_q  [QW+1];
  logic [AW-1:0] dv_ae_q  [QW+1];
  logic [AW-1:0] dv_ap_q  [QW+1];

  for (genvar k = 0; k <= QW; k++) begin : g_div
    logic          vld_s, qg_s, qb_s, qg_n, qb_n;
    logic [PW-1:0] pl_s;
    logic [DW-1:0] den_s;
    logic [RW-1:0] rg_s, rb_s, rg_n, rb_n, rg_t, rb_t;
    logic [AW-1:0] ae_s, ap_s, ae_n, ap_n;
    logic [NW-1:0] ng, nb;
    logic [OW-1:0] a1, a2, b1, b2;
    logic [AW-1:0] a1x, a2x, b1x, b2x;

    if (k == 0) begin : g_src0
      logic [NW-1:0] ng0, nb0;
      assign ng0   = NW'(sq_pl_q[RB-1][PW-1 -: SW]) << NSH;
      assign nb0   = NW'(sq_pl_q[RB-1][PW-SW-1 -: SW]) << NSH;
      assign vld_s = sq_vld_q[RB-1];
      assign pl_s  = sq_pl_q[RB-1];
      assign den_s = {sq_root_q[RB-1], 1'b0};
      assign rg_s  = RW'(ng0 >> QW);
      assign rb_s  = RW'(nb0 >> QW);
      assign qg_s  = 1'b0;
      assign qb_s  = 1'b0;
      assign ae_s  = '0;
      assign ap_s  = '0;
    end else begin : g_srck
      assign vld_s = dv_vld_q[k-1];
      assign pl_s  = dv_pl_q[k-1];
      assign den_s = dv_den_q[k-1];
      assign rg_s  = dv_rg_q[k-1];
      assign rb_s  = dv_rb_q[k-1];
      assign qg_s  = dv_qg_q[k-1];
      assign qb_s  = dv_qb_q[k-1];
      assign ae_s  = dv_ae_q[k-1];
      assign ap_s  = dv_ap_q[k-1];
    end

    assign ng  = NW'(pl_s[PW-1 -: SW]) << NSH;
    assign nb  = NW'(pl_s[PW-SW-1 -: SW]) << NSH;
    assign a1  = pl_s[4*OW-1 -: OW];
    assign a2  = pl_s[3*OW-1 -: OW];
    assign b1  = pl_s[2*OW-1 -: OW];
    assign b2  = pl_s[OW-1:0];
    assign a1x = {{(AW-OW){a1[OW-1]}}, a1};
    assign a2x = {{(AW-OW){a2[OW-1]}}, a2};
    assign b1x = {{(AW-OW){b1[OW-1]}}, b1};
    assign b2x = {{(AW-OW){b2[OW-1]}}, b2};

    // restoring divide step, one quotient bit each
    if (k < QW) begin : g_step
      localparam int unsigned I = QW - 1 - k;
      always_comb begin
        rg_t = {rg_s[RW-2:0], ng[I]};
        rb_t = {rb_s[RW-2:0], nb[I]};
        qg_n = (rg_t >= RW'(den_s));
        qb_n = (rb_t >= RW'(den_s));
        rg_n = qg_n ? (rg_t - RW'(den_s)) : rg_t;
        rb_n = qb_n ? (rb_t - RW'(den_s)) : rb_t;
      end
    end else begin : g_last
      assign rg_t = rg_s;
      assign rb_t = rb_s;
      assign rg_n = rg_t;
      assign rb_n = rb_t;
      assign qg_n = 1'b0;
      assign qb_n = ng[0] & 1'b0;
    end

    // horner step with the previous stage's quotient bits
    always_comb begin
      ae_n = {ae_s[AW-2:0], 1'b0} + (qg_s ? a1x : '0) + (qb_s ? a2x : '0);
      ap_n = {ap_s[AW-2:0], 1'b0} + (qg_s ? b1x : '0) + (qb_s ? b2x : '0);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_pl_q[k]  <= pl_s;
        dv_den_q[k] <= den_s;
        dv_rg_q[k]  <= rg_n;
        dv_rb_q[k]  <= rb_n;
        dv_qg_q[k]  <= qg_n;
        dv_qb_q[k]  <= qb_n;
        dv_ae_q[k]  <= ae_n;
        dv_ap_q[k]  <= ap_n;
      end
    end
  end

  // round half up and drop the coefficient fraction
  logic           rn_vld_q;
  logic [RDW-1:0] rn_e_q, rn_p_q;
  logic [AW-1:0]  re_sum, rp_sum;

  assign re_sum = dv_ae_q[QW] + (AW'(1) << (CB - 1));
  assign rp_sum = dv_ap_q[QW] + (AW'(1) << (CB - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_vld_q <= 1'b0;
    end else if (adv) begin
      rn_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn_e_q <= re_sum[AW-1:CB];
      rn_p_q <= rp_sum[AW-1:CB];
    end
  end

  // clamp to the momentum range
  logic         ovf_e, ovf_p;
  logic [W-1:0] sat_e, sat_p, res_e, res_p;
  logic         out_vld_q, sat_q;
  logic [W-1:0] out_e_q, out_p_q;

  always_comb begin
    ovf_e = (rn_e_q[RDW-1:W-1] != '0) && (rn_e_q[RDW-1:W-1] != '1);
    ovf_p = (rn_p_q[RDW-1:W-1] != '0) && (rn_p_q[RDW-1:W-1] != '1);
    sat_e = rn_e_q[RDW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat_p = rn_p_q[RDW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    res_e = ovf_e ? sat_e : rn_e_q[W-1:0];
    res_p = ovf_p ? sat_p : rn_p_q[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= rn_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_e_q <= res_e;
      out_p_q <= res_p;
      sat_q   <= ovf_e | ovf_p;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign energy_out_o     = out_e_q;
  assign momentum_z_out_o = out_p_q;
  assign saturated_o      = sat_q;

endmodule
